// ===== rtl/text_console_cursor_writer_macros.svh =====
// Assertion macros for the console cursor writer RTL.
`ifndef TEXT_CONSOLE_CURSOR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCCW_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tccw assertion failed");

// Next-cycle implication, checked outside reset.
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tccw assertion failed");

`endif

// ===== rtl/tccw_pkg.sv =====
// Shared types, codes and constants of the console cursor writer.
package tccw_pkg;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int IDX_W   = 11;
  localparam int DATA_W  = 16;
  localparam int COLOR_W = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Parameter defaults
  localparam int TAB_STOP_DEF    = 8;
  localparam int MAX_COLUMNS_DEF = 80;
  localparam int MAX_ROWS_DEF    = 25;

  // Register reset values
  localparam logic [COL_W-1:0]   COLUMNS_RST = 7'd80;
  localparam logic [ROW_W-1:0]   ROWS_RST    = 5'd25;
  localparam logic [COLOR_W-1:0] COLOR_RST   = 8'd7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR   = 2'd2;

  // Control character codes
  localparam logic [CHAR_W-1:0] CODE_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CODE_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CODE_CR  = 8'h0D;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_LF,
    OP_CR,
    OP_TAB,
    OP_VT,
    OP_FF
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
  } entry_t;

  // Decode a byte into a cursor operation
  function automatic op_t classify(input logic [CHAR_W-1:0] c);
    op_t o;
    case (c)
      CODE_LF:  o = OP_LF;
      CODE_CR:  o = OP_CR;
      CODE_TAB: o = OP_TAB;
      CODE_VT:  o = OP_VT;
      CODE_FF:  o = OP_FF;
      default:  o = OP_PRINT;
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/text_console_cursor_writer.sv =====
// Text console cursor writer: top level with configuration registers.
//
// Input channel: in_valid / in_stall carry one character byte per transaction.
// Output channel: out_valid / out_stall carry one result per character: the
// cell write (write_enable, write_index, write_data) and the new cursor.
// Configuration: cfg_write with cfg_index 0 (columns), 1 (rows), 2 (colour)
// and cfg_data; write only while no transaction is in flight.
// Path: an accepted character is written into the 2-entry queue, is loaded
// from there into the output register and is then offered to the receiver.
// Throughput is one character per cycle while the receiver does not stall;
// the cursor update and the single 5x7 index multiply feed the result register.
// When the receiver stalls, the result register holds, the queue fills, and
// in_stall rises once both queue entries are taken.
// Reset (rst, synchronous) empties the queue and result register, puts the
// cursor at row 0, column 0 and loads 80 columns, 25 rows, colour 7.
module text_console_cursor_writer #(
  parameter int TAB_STOP    = tccw_pkg::TAB_STOP_DEF,
  parameter int MAX_COLUMNS = tccw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tccw_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tccw_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tccw_pkg::CHAR_W-1:0]   character,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          write_enable,
  output logic [tccw_pkg::IDX_W-1:0]    write_index,
  output logic [tccw_pkg::DATA_W-1:0]   write_data,
  output logic [tccw_pkg::ROW_W-1:0]    cursor_row,
  output logic [tccw_pkg::COL_W-1:0]    cursor_col
);
  import tccw_pkg::*;

  `include "text_console_cursor_writer_macros.svh"

  logic [COL_W-1:0]   screen_columns;
  logic [ROW_W-1:0]   screen_rows;
  logic [COLOR_W-1:0] text_colour;

  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_empty;
  entry_t push_entry;
  entry_t pop_entry;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= COLUMNS_RST;
      screen_rows    <= ROWS_RST;
      text_colour    <= COLOR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLUMNS: screen_columns <= cfg_data[COL_W-1:0];
        REG_ROWS:    screen_rows    <= cfg_data[ROW_W-1:0];
        REG_COLOR:   text_colour    <= cfg_data[COLOR_W-1:0];
        default:     screen_columns <= screen_columns;
      endcase
    end
  end

  tccw_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .character  (character),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tccw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  tccw_back #(
    .TAB_STOP    (TAB_STOP),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .screen_columns (screen_columns),
    .screen_rows    (screen_rows),
    .text_colour    (text_colour),
    .queue_empty    (queue_empty),
    .pop_entry      (pop_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .write_enable   (write_enable),
    .write_index    (write_index),
    .write_data     (write_data),
    .cursor_row     (cursor_row),
    .cursor_col     (cursor_col)
  );

  // Control results carry no cell write
  `TCCW_ASSERT_IMPL(a_ctrl_zero, clk, rst, out_valid && !write_enable,
                    write_index == '0 && write_data == '0)
  // A written cell never holds a control code
  `TCCW_ASSERT_IMPL(a_print_class, clk, rst, out_valid && write_enable,
                    write_data[7:0] != CODE_LF && write_data[7:0] != CODE_CR &&
                    write_data[7:0] != CODE_TAB && write_data[7:0] != CODE_VT &&
                    write_data[7:0] != CODE_FF)
  // Nothing can reach the output the cycle after a push into an empty path
  `TCCW_ASSERT_NEXT(a_no_bypass, clk, rst, !out_valid && queue_empty,
                    !out_valid)

endmodule

// ===== rtl/tccw_queue.sv =====
// Short register queue between the front and back parts.
module tccw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tccw_pkg::entry_t push_entry,
  input  logic            pop,
  output tccw_pkg::entry_t pop_entry,
  output logic            full,
  output logic            empty
);
  import tccw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/tccw_front.sv =====
// Front part: takes characters and classifies them into cursor operations.
module tccw_front (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [tccw_pkg::CHAR_W-1:0] character,
  input  logic                     queue_full,
  output logic                     push,
  output tccw_pkg::entry_t         push_entry
);
  import tccw_pkg::*;

  // Accept whenever the queue has room
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Classify the byte once, on the way in
  always_comb begin
    push_entry.op = classify(character);
    push_entry.ch = character;
  end

endmodule

// ===== rtl/tccw_back.sv =====
// Back part: cursor state, cell index and the registered result stage.
module tccw_back #(
  parameter int TAB_STOP    = tccw_pkg::TAB_STOP_DEF,
  parameter int MAX_COLUMNS = tccw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tccw_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tccw_pkg::COL_W-1:0]  screen_columns,
  input  logic [tccw_pkg::ROW_W-1:0]  screen_rows,
  input  logic [tccw_pkg::COLOR_W-1:0] text_colour,
  input  logic                        queue_empty,
  input  tccw_pkg::entry_t            pop_entry,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        write_enable,
  output logic [tccw_pkg::IDX_W-1:0]  write_index,
  output logic [tccw_pkg::DATA_W-1:0] write_data,
  output logic [tccw_pkg::ROW_W-1:0]  cursor_row,
  output logic [tccw_pkg::COL_W-1:0]  cursor_col
);
  import tccw_pkg::*;

  localparam int PH_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int PROD_W = ROW_W + COL_W;

  // Cursor state; tab_phase tracks column modulo the tab stop
  logic [COL_W-1:0] column_position;
  logic [ROW_W-1:0] row_position;
  logic [PH_W-1:0]  tab_phase;

  logic [COL_W-1:0] cols;
  logic [ROW_W-1:0] rows;

  logic             wrap0;
  logic [COL_W-1:0] c0;
  logic [ROW_W:0]   r0_inc;
  logic [ROW_W-1:0] r0;
  logic [PH_W-1:0]  p0;

  logic [COL_W:0]   c1;
  logic [ROW_W:0]   r1;
  logic [PH_W-1:0]  p1;

  logic             wrap1;
  logic [COL_W-1:0] column_next;
  logic [ROW_W:0]   r2_inc;
  logic [ROW_W-1:0] row_next;
  logic [PH_W-1:0]  phase_next;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] cell_idx;
  logic              is_print;

  // Effective screen size
  always_comb begin
    if (screen_columns == '0) begin
      cols = COL_W'(1);
    end else if ({1'b0, screen_columns} > (COL_W+1)'(MAX_COLUMNS)) begin
      cols = COL_W'(MAX_COLUMNS);
    end else begin
      cols = screen_columns;
    end
    if (screen_rows == '0) begin
      rows = ROW_W'(1);
    end else if ({2'b0, screen_rows} > (ROW_W+2)'(MAX_ROWS)) begin
      rows = ROW_W'(MAX_ROWS);
    end else begin
      rows = screen_rows;
    end
  end

  // Bring a stale cursor back on screen
  always_comb begin
    wrap0  = (column_position >= cols);
    c0     = wrap0 ? '0 : column_position;
    p0     = wrap0 ? '0 : tab_phase;
    r0_inc = {1'b0, row_position} + (ROW_W+1)'(wrap0);
    r0     = (r0_inc >= {1'b0, rows}) ? '0 : r0_inc[ROW_W-1:0];
  end

  // Apply the operation
  always_comb begin
    c1 = {1'b0, c0};
    r1 = {1'b0, r0};
    p1 = p0;
    is_print = 1'b0;
    case (pop_entry.op)
      OP_LF: begin
        r1 = {1'b0, r0} + 1'b1;
        c1 = '0;
        p1 = '0;
      end
      OP_CR: begin
        c1 = '0;
        p1 = '0;
      end
      OP_TAB: begin
        c1 = {1'b0, c0} + ((COL_W+1)'(TAB_STOP) - (COL_W+1)'(p0));
        p1 = '0;
      end
      OP_VT: begin
        r1 = {1'b0, r0} + 1'b1;
      end
      OP_FF: begin
        c1 = {1'b0, c0};
      end
      default: begin
        is_print = 1'b1;
        c1 = {1'b0, c0} + 1'b1;
        p1 = (p0 == PH_W'(TAB_STOP - 1)) ? '0 : p0 + 1'b1;
      end
    endcase
  end

  // Wrap after the move
  always_comb begin
    wrap1       = (c1 >= {1'b0, cols});
    column_next = wrap1 ? '0 : c1[COL_W-1:0];
    phase_next  = wrap1 ? '0 : p1;
    r2_inc      = r1 + (ROW_W+1)'(wrap1);
    row_next    = (r2_inc >= {1'b0, rows}) ? '0 : r2_inc[ROW_W-1:0];
  end

  // Cell index row*columns+col
  assign prod     = PROD_W'(r0) * PROD_W'(cols);
  assign cell_idx = prod + PROD_W'(c0);

  // Take a queued operation when the result register is free or draining
  assign pop = !queue_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      tab_phase       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        column_position <= column_next;
        row_position    <= row_next;
        tab_phase       <= phase_next;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      write_enable <= is_print;
      write_index  <= is_print ? cell_idx[IDX_W-1:0] : '0;
      write_data   <= is_print ? {text_colour, pop_entry.ch} : '0;
      cursor_row   <= row_next;
      cursor_col   <= column_next;
    end
  end

endmodule

// ===== sim/text_console_cursor_writer_tb.sv =====
// Self-checking testbench for the text console cursor writer: directed and random traffic with scoreboard.
`timescale 1ns / 100ps

module text_console_cursor_writer_tb;
  import tccw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_CHARS = 140;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  // One expected cell write plus cursor
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cell_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    character = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 write_enable;
  logic [IDX_W-1:0]     write_index;
  logic [DATA_W-1:0]    write_data;
  logic [ROW_W-1:0]     cursor_row;
  logic [COL_W-1:0]     cursor_col;

  // Shadow registers and cursor of the predictor
  logic [COL_W-1:0]   columns_reg = COLUMNS_RST;
  logic [ROW_W-1:0]   rows_reg = ROWS_RST;
  logic [COLOR_W-1:0] colour_reg = COLOR_RST;
  int cur_row = 0;
  int cur_col = 0;

  logic [CHAR_W-1:0] char_backlog[$];
  cell_result_t      pending_cells[$];
  cell_result_t      seen_cell;
  cell_result_t      want_cell;

  int errors = 0;
  int chars_sent = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int next_hold_at = 300;
  int mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  text_console_cursor_writer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .character    (character),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cursor_row   (cursor_row),
    .cursor_col   (cursor_col)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Wrap rule: column past width goes to next row, row past height goes to 0
  function automatic void fold_cursor(input int cols, input int rows);
    if (cur_col >= cols) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= rows) cur_row = 0;
  endfunction

  // Cursor and cell write caused by one character
  function automatic cell_result_t predict_cell(input logic [CHAR_W-1:0] ch);
    cell_result_t r;
    int cols;
    int rows;
    cols = (columns_reg == 0) ? 1 :
           (columns_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(columns_reg);
    rows = (rows_reg == 0) ? 1 :
           (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_reg);
    r = '0;
    fold_cursor(cols, rows);
    case (ch)
      CODE_LF: begin
        cur_row++;
        cur_col = 0;
      end
      CODE_CR: cur_col = 0;
      CODE_TAB: cur_col += TAB_STOP_DEF - (cur_col % TAB_STOP_DEF);
      CODE_VT: cur_row++;
      CODE_FF: ;
      default: begin
        r.we = 1'b1;
        r.idx = IDX_W'(cur_row * cols + cur_col);
        r.data = {colour_reg, ch};
        cur_col++;
      end
    endcase
    fold_cursor(cols, rows);
    r.row = ROW_W'(cur_row);
    r.col = COL_W'(cur_col);
    return r;
  endfunction

  // Mostly printable bytes, a good share of control codes
  function automatic logic [CHAR_W-1:0] random_char();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 4))
        0: c = CODE_LF;
        1: c = CODE_CR;
        2: c = CODE_TAB;
        3: c = CODE_VT;
        default: c = CODE_FF;
      endcase
    end else begin
      c = CHAR_W'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("[%0t] mismatch: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Register write; shadow copy follows the same masking
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_COLUMNS: columns_reg = val[COL_W-1:0];
      REG_ROWS:    rows_reg = val[ROW_W-1:0];
      REG_COLOR:   colour_reg = val[COLOR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every queued transaction has been sent and checked
  task automatic settle();
    while (char_backlog.size() != 0 || in_valid || pending_cells.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_cells.push_back(predict_cell(character));
        void'(char_backlog.pop_front());
        chars_sent++;
      end
      if (in_valid && in_stall) begin
        // stalled payload holds
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (char_backlog.size() != 0) begin
        in_valid <= 1'b1;
        character <= char_backlog[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with occasional long hold-offs to fill the block
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (holds_done < 2 && chars_sent >= next_hold_at) begin
      out_stall <= 1'b1;
      hold_left = $urandom_range(40, 90);
      holds_done++;
      next_hold_at = chars_sent + 500;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
        STALL_TOGGLE: out_stall <= ~out_stall;
      endcase
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_cell = {write_enable, write_index, write_data, cursor_row, cursor_col};
      if (pending_cells.size() == 0) begin
        report_mismatch("unexpected result", int'(seen_cell.idx), 0);
      end else begin
        want_cell = pending_cells.pop_front();
        if (seen_cell.we !== want_cell.we)
          report_mismatch("write_enable", int'(seen_cell.we), int'(want_cell.we));
        if (seen_cell.idx !== want_cell.idx)
          report_mismatch("write_index", int'(seen_cell.idx), int'(want_cell.idx));
        if (seen_cell.data !== want_cell.data)
          report_mismatch("write_data", int'(seen_cell.data), int'(want_cell.data));
        if (seen_cell.row !== want_cell.row)
          report_mismatch("cursor_row", int'(seen_cell.row), int'(want_cell.row));
        if (seen_cell.col !== want_cell.col)
          report_mismatch("cursor_col", int'(seen_cell.col), int'(want_cell.col));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus phases
  initial begin
    logic [CFG_W-1:0] cv;
    wait (!rst);
    @(negedge clk);

    // Default screen: byte extremes and every control code
    char_backlog.push_back(8'h00);
    char_backlog.push_back(8'hFF);
    char_backlog.push_back(8'h41);
    char_backlog.push_back(CODE_TAB);
    char_backlog.push_back(8'h7F);
    char_backlog.push_back(CODE_CR);
    char_backlog.push_back(CODE_FF);
    char_backlog.push_back(CODE_LF);
    char_backlog.push_back(CODE_VT);
    char_backlog.push_back(8'h80);
    settle();

    // Tiny 3x2 screen: column wrap, tab past the edge, row wrap
    write_reg(REG_COLUMNS, 8'h83);
    write_reg(REG_ROWS, 8'h02);
    write_reg(REG_COLOR, 8'hF0);
    char_backlog.push_back(8'h78);
    char_backlog.push_back(8'h79);
    char_backlog.push_back(8'h7A);
    char_backlog.push_back(CODE_TAB);
    char_backlog.push_back(8'h71);
    char_backlog.push_back(CODE_LF);
    char_backlog.push_back(CODE_VT);
    settle();

    // Move the cursor out, then shrink the screen under it
    write_reg(REG_COLUMNS, 8'd80);
    write_reg(REG_ROWS, 8'd25);
    char_backlog.push_back(CODE_TAB);
    char_backlog.push_back(CODE_TAB);
    char_backlog.push_back(CODE_TAB);
    settle();
    write_reg(REG_COLUMNS, 8'h00);
    write_reg(REG_ROWS, 8'h00);
    write_reg(REG_UNUSED, 8'hFF);
    char_backlog.push_back(8'h41);
    char_backlog.push_back(CODE_FF);
    settle();

    // Oversized screen values clamp to the maximum
    write_reg(REG_COLUMNS, 8'hFF);
    write_reg(REG_ROWS, 8'hFF);
    write_reg(REG_COLOR, 8'hFF);
    char_backlog.push_back(8'h42);
    char_backlog.push_back(CODE_TAB);
    settle();

    // Random phases with a fresh screen setup each
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0: cv = 8'd0;
        1: cv = 8'd1;
        2: cv = 8'd80;
        3: cv = 8'd127;
        default: cv = CFG_W'($urandom_range(1, 80));
      endcase
      cv[7] = 1'($urandom_range(0, 1));
      write_reg(REG_COLUMNS, cv);
      case ($urandom_range(0, 5))
        0: cv = 8'd0;
        1: cv = 8'd1;
        2: cv = 8'd25;
        3: cv = 8'd31;
        default: cv = CFG_W'($urandom_range(1, 25));
      endcase
      cv[7:5] = 3'($urandom_range(0, 7));
      write_reg(REG_ROWS, cv);
      write_reg(REG_COLOR, CFG_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 255)));
      for (int n = 0; n < PHASE_CHARS; n++)
        char_backlog.push_back(random_char());
      settle();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== text_console_cursor_writer.f =====
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_queue.sv
rtl/tccw_front.sv
rtl/tccw_back.sv
rtl/text_console_cursor_writer.sv
sim/text_console_cursor_writer_tb.sv
